/* design/urs_pkg.sv */
package urs_pkg;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_TRIG_LOW  = 3'd1,
        PH_TRIG_HIGH = 3'd2,
        PH_WAIT_RISE = 3'd3,
        PH_MEASURE   = 3'd4
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_ECHO  = 2'd1,
        ST_TOO_LONG = 2'd2
    } t_status;

    localparam int CountW    = 17;
    localparam int DistW     = 8;
    localparam int ServoW    = 10;
    localparam int BaseW     = 9;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 16;
    localparam int InDataW   = 8;
    localparam int OutDataW  = 24;

    // register indexes on the config port
    localparam logic [CfgAddrW-1:0] REG_RISE_TMO  = 3'd0;
    localparam logic [CfgAddrW-1:0] REG_WIDTH_TMO = 3'd1;
    localparam logic [CfgAddrW-1:0] REG_MAX_DIST  = 3'd2;
    localparam logic [CfgAddrW-1:0] REG_TRIG_W    = 3'd3;
    localparam logic [CfgAddrW-1:0] REG_SERVO_BASE = 3'd4;

    localparam logic [CountW-1:0] LOW_TICKS = 17'd2;

    // count/58 == (count * 144632) >> 23, exact for count < 174762
    localparam logic [17:0] DIV58_MUL   = 18'd144632;
    localparam int          DIV58_SHIFT = 23;
    // floor(6*d/5) == (d * 6 * 1639) >> 13, exact for d < 455
    localparam logic [13:0] SERVO_MUL   = 14'd9834;
    localparam int          SERVO_SHIFT = 13;

    // front-end result of one tick, before distance scaling
    typedef struct packed {
        logic                trig;
        logic                busy;
        logic                done;
        t_status             status;
        logic [CountW-1:0]   count;
    } t_meas;

    typedef struct packed {
        logic                trig;
        logic                busy;
        logic                done;
        logic [DistW-1:0]    distance;
        t_status             status;
        logic [ServoW-1:0]   servo;
        logic                servo_valid;
    } t_res;

endpackage

/* design/urs_scale.sv */
module urs_scale (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  urs_pkg::t_meas                i_meas,
    input  logic [urs_pkg::DistW-1:0]     i_max_dist,
    input  logic [urs_pkg::BaseW-1:0]     i_servo_base,
    output logic                          o_valid,
    output urs_pkg::t_res                 o_res
);

    logic                  r_v2;
    logic                  r_v3;
    urs_pkg::t_res         r_s2;
    urs_pkg::t_res         r_s3;
    urs_pkg::t_res         n_s2;
    urs_pkg::t_res         n_s3;

    logic [34:0]           w_prod58;
    logic [11:0]           w_quot;
    logic [12:0]           w_dist_full;
    logic [21:0]           w_prod_srv;
    logic [8:0]            w_scaled;

    // stage 2: distance = count/58 + 1, clamped, for a done OK result; else zero
    always_comb begin
        w_prod58    = 35'(i_meas.count) * 35'(urs_pkg::DIV58_MUL);
        w_quot      = 12'(w_prod58 >> urs_pkg::DIV58_SHIFT);
        w_dist_full = 13'(w_quot) + 13'd1;
        n_s2             = '0;
        n_s2.trig        = i_meas.trig;
        n_s2.busy        = i_meas.busy;
        n_s2.done        = i_meas.done;
        n_s2.status      = i_meas.status;
        if (i_meas.done && i_meas.status == urs_pkg::ST_OK) begin
            if (w_dist_full > 13'(i_max_dist)) begin
                n_s2.distance = i_max_dist;
            end else begin
                n_s2.distance = w_dist_full[urs_pkg::DistW-1:0];
            end
        end
    end

    // stage 3: servo = base + floor(6*distance/5) when done and distance is nonzero; else zero
    always_comb begin
        w_prod_srv = 22'(r_s2.distance) * 22'(urs_pkg::SERVO_MUL);
        w_scaled   = 9'(w_prod_srv >> urs_pkg::SERVO_SHIFT);
        n_s3       = r_s2;
        if (r_s2.done && r_s2.distance != '0) begin
            n_s3.servo       = 10'(i_servo_base) + 10'(w_scaled);
            n_s3.servo_valid = 1'b1;
        end else begin
            n_s3.servo       = '0;
            n_s3.servo_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_adv) begin
            r_v2 <= i_valid;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_valid = r_v3;
    assign o_res   = r_s3;

endmodule

/* design/ultrasonic_range_to_servo.sv */
// channel   dir  width  contents
// s_axis    in   8      tick: echo level, start request
// m_axis    out  24     tick result: trigger, busy, done, distance, status, servo
// cfg       in   16     register writes, index 0..4
//
// One tick is accepted per cycle while the output is not stalled; its result
// is registered by phase update, divide by 58 and clamp, then servo scaling.
// The phase/count state moves only on an accepted beat, so stalls on either
// side freeze the measurement. All three stages advance together when the
// output register is empty or being taken. Reset is synchronous, active low,
// and restores the register defaults.
module ultrasonic_range_to_servo (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [0] echo_level, [1] start_req, [7:2] zero
    input  logic [urs_pkg::InDataW-1:0]      s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [0] trigger_out, [1] busy_res, [2] done_res, [10:3] distance_cm,
    // [12:11] status, [22:13] servo_value, [23] servo_valid
    output logic [urs_pkg::OutDataW-1:0]     m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [urs_pkg::CfgAddrW-1:0]     i_cfg_addr,
    input  logic [urs_pkg::CfgDataW-1:0]     i_cfg_wdata
);

    logic [15:0]                 r_rise_tmo;
    logic [15:0]                 r_width_tmo;
    logic [urs_pkg::DistW-1:0]   r_max_dist;
    logic [7:0]                  r_trig_w;
    logic [urs_pkg::BaseW-1:0]   r_servo_base;

    urs_pkg::t_phase             r_phase;
    urs_pkg::t_phase             n_phase;
    logic [urs_pkg::CountW-1:0]  r_count;
    logic [urs_pkg::CountW-1:0]  n_count;
    logic [urs_pkg::CountW-1:0]  w_inc;

    logic                        r_v1;
    urs_pkg::t_meas              r_meas;
    urs_pkg::t_meas              n_meas;

    logic                        w_adv;
    logic                        w_acc;
    logic                        w_echo;
    logic                        w_start;
    logic                        w_out_valid;
    urs_pkg::t_res               w_res;

    assign w_adv         = !w_out_valid || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign w_acc         = s_axis_tvalid && w_adv;
    assign w_echo        = s_axis_tdata[0];
    assign w_start       = s_axis_tdata[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_tmo   <= 16'd5000;
            r_width_tmo  <= 16'd30000;
            r_max_dist   <= 8'd50;
            r_trig_w     <= 8'd10;
            r_servo_base <= 9'd160;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                urs_pkg::REG_RISE_TMO:   r_rise_tmo   <= i_cfg_wdata;
                urs_pkg::REG_WIDTH_TMO:  r_width_tmo  <= i_cfg_wdata;
                urs_pkg::REG_MAX_DIST:   r_max_dist   <= i_cfg_wdata[7:0];
                urs_pkg::REG_TRIG_W:     r_trig_w     <= i_cfg_wdata[7:0];
                urs_pkg::REG_SERVO_BASE: r_servo_base <= i_cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_inc   = r_count + 17'd1;
        n_phase = r_phase;
        n_count = r_count;
        n_meas  = '0;
        n_meas.status = urs_pkg::ST_OK;
        unique case (r_phase)
            urs_pkg::PH_TRIG_LOW: begin
                n_count = w_inc;
                if (w_inc >= urs_pkg::LOW_TICKS) begin
                    n_phase = urs_pkg::PH_TRIG_HIGH;
                    n_count = '0;
                end
            end
            urs_pkg::PH_TRIG_HIGH: begin
                n_meas.trig = 1'b1;
                n_count     = w_inc;
                if (w_inc >= 17'(r_trig_w)) begin
                    n_phase = urs_pkg::PH_WAIT_RISE;
                    n_count = '0;
                end
            end
            urs_pkg::PH_WAIT_RISE: begin
                if (w_echo) begin
                    n_phase = urs_pkg::PH_MEASURE;
                    n_count = 17'd1;  // rise tick is the first high tick
                end else begin
                    n_count = w_inc;
                    if (w_inc > 17'(r_rise_tmo)) begin
                        n_phase       = urs_pkg::PH_IDLE;
                        n_count       = '0;
                        n_meas.done   = 1'b1;
                        n_meas.status = urs_pkg::ST_NO_ECHO;
                    end
                end
            end
            urs_pkg::PH_MEASURE: begin
                if (!w_echo) begin
                    n_phase      = urs_pkg::PH_IDLE;
                    n_count      = '0;
                    n_meas.done  = 1'b1;
                    n_meas.count = r_count;
                end else begin
                    n_count = w_inc;
                    if (w_inc > 17'(r_width_tmo)) begin
                        n_phase       = urs_pkg::PH_IDLE;
                        n_count       = '0;
                        n_meas.done   = 1'b1;
                        n_meas.status = urs_pkg::ST_TOO_LONG;
                    end
                end
            end
            default: begin
                n_phase = urs_pkg::PH_IDLE;
                if (w_start) begin
                    n_phase = urs_pkg::PH_TRIG_LOW;
                    n_count = 17'd1;  // start tick is the first low tick
                end
            end
        endcase
        n_meas.busy = (n_phase != urs_pkg::PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= urs_pkg::PH_IDLE;
            r_count <= '0;
        end else if (w_acc) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_meas <= n_meas;
        end
    end

    urs_scale u_scale (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (w_adv),
        .i_valid      (r_v1),
        .i_meas       (r_meas),
        .i_max_dist   (r_max_dist),
        .i_servo_base (r_servo_base),
        .o_valid      (w_out_valid),
        .o_res        (w_res)
    );

    assign m_axis_tvalid = w_out_valid;
    assign m_axis_tdata  = {w_res.servo_valid, w_res.servo, w_res.status,
                            w_res.distance, w_res.done, w_res.busy, w_res.trig};

    a_servo_needs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[23] |-> m_axis_tdata[2])
        else $error("servo_valid without done");

    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[1] && m_axis_tdata[2]))
        else $error("busy and done on the same tick");

    a_start_from_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && r_phase == urs_pkg::PH_IDLE && w_start
        |=> r_phase == urs_pkg::PH_TRIG_LOW)
        else $error("start in idle did not enter trigger low");

    a_phase_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_phase) && $stable(r_count))
        else $error("measurement state moved without a tick");

endmodule
